[hdl/rtphx_pkg.sv]
// Constants and types for the RTP header-extension parser.
// No dependencies.
package rtphx_pkg;

  localparam logic [15:0] ProfileOneByte = 16'hBEDE;
  localparam logic [15:0] ProfileTwoByte = 16'h1000;
  localparam logic [15:0] ProfileTwoMask = 16'hFFF0;
  localparam logic [7:0]  IdReserved     = 8'h0F;

  localparam logic [1:0] KindPayload   = 2'd0;
  localparam logic [1:0] KindEmpty     = 2'd1;
  localparam logic [1:0] KindMalformed = 2'd2;

  typedef enum logic [2:0] {
    ModeIgnore = 3'b001,
    ModeOne    = 3'b010,
    ModeTwo    = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    PhaseId   = 3'b001,
    PhaseLen  = 3'b010,
    PhaseData = 3'b100
  } phase_e;

endpackage

[hdl/rtp_header_extension_parser.sv]
// RTP header-extension parser: one-byte (0xBEDE) and two-byte (0x100x) forms.
// Depends on rtphx_pkg.
// Path: a result passes the input register and then the output register, held
// longer while an earlier result beat waits on out_ready_i.
// Throughput: one byte per cycle unless a result beat waits on out_ready_i; the
// input register feeds the per-byte state update, which writes the output register in the same cycle.
// Reset: asynchronous; clears all parser state, the block ignores bytes until
// a block start arrives.
module rtp_header_extension_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ext_byte_i,
  input  logic        block_start_i,
  input  logic        block_end_i,
  input  logic [15:0] profile_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  element_id_o,
  output logic        two_byte_format_o,
  output logic [7:0]  byte_offset_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  element_length_o,
  output logic        element_last_o
);
  import rtphx_pkg::*;

  // input register
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        start_q, end_q;
  logic [15:0] prof_q;

  // parser state
  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  offs_q, offs_d;

  // working values after block-start override
  mode_e       mode_w;
  phase_e      phase_w;
  logic [7:0]  id_w, len_w, left_w, offs_w;
  logic [7:0]  hdr_id;
  logic [7:0]  one_len;
  logic        stop;

  // result
  logic        res_v;
  logic [1:0]  res_kind;
  logic [7:0]  res_id, res_offs, res_data, res_len;
  logic        res_last;

  logic        advance;

  assign advance    = in_valid_q && (!out_valid_o || out_ready_i || !res_v);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= ext_byte_i;
      start_q <= block_start_i;
      end_q   <= block_end_i;
      prof_q  <= profile_word_i;
    end
  end

  assign hdr_id  = (mode_w == ModeOne) ? {4'd0, byte_q[7:4]} : byte_q;
  assign one_len = {4'd0, byte_q[3:0]} + 8'd1;

  always_comb begin
    mode_w  = mode_q;
    phase_w = phase_q;
    id_w    = id_q;
    len_w   = len_q;
    left_w  = left_q;
    offs_w  = offs_q;
    if (start_q) begin
      if (prof_q == ProfileOneByte) begin
        mode_w = ModeOne;
      end else if ((prof_q & ProfileTwoMask) == ProfileTwoByte) begin
        mode_w = ModeTwo;
      end else begin
        mode_w = ModeIgnore;
      end
      phase_w = PhaseId;
      id_w    = '0;
      len_w   = '0;
      left_w  = '0;
      offs_w  = '0;
    end

    mode_d   = mode_w;
    phase_d  = phase_w;
    id_d     = id_w;
    len_d    = len_w;
    left_d   = left_w;
    offs_d   = offs_w;
    stop     = 1'b0;
    res_v    = 1'b0;
    res_kind = KindPayload;
    res_id   = '0;
    res_offs = '0;
    res_data = '0;
    res_len  = '0;
    res_last = 1'b0;

    if (mode_w == ModeIgnore) begin
      phase_d = PhaseId;
    end else begin
      case (phase_w)
        PhaseId: begin
          // id 0 is padding and is skipped
          if (hdr_id != 8'd0) begin
            id_d = hdr_id;
            if (hdr_id >= IdReserved) begin
              res_v    = 1'b1;
              res_kind = KindMalformed;
              res_id   = hdr_id;
              stop     = 1'b1;
            end else if (mode_w == ModeOne) begin
              len_d = one_len;
              if (end_q) begin
                res_v    = 1'b1;
                res_kind = KindMalformed;
                res_id   = hdr_id;
                res_len  = one_len;
                stop     = 1'b1;
              end else begin
                left_d  = one_len;
                offs_d  = '0;
                phase_d = PhaseData;
              end
            end else begin
              len_d = '0;
              if (end_q) begin
                res_v    = 1'b1;
                res_kind = KindMalformed;
                res_id   = hdr_id;
                stop     = 1'b1;
              end else begin
                phase_d = PhaseLen;
              end
            end
          end
        end
        PhaseLen: begin
          len_d = byte_q;
          if (byte_q == 8'd0) begin
            res_v    = 1'b1;
            res_kind = KindEmpty;
            res_id   = id_w;
            res_last = 1'b1;
            phase_d  = PhaseId;
          end else if (end_q) begin
            res_v    = 1'b1;
            res_kind = KindMalformed;
            res_id   = id_w;
            res_len  = byte_q;
            stop     = 1'b1;
          end else begin
            left_d  = byte_q;
            offs_d  = '0;
            phase_d = PhaseData;
          end
        end
        PhaseData: begin
          if (left_w <= 8'd1) begin
            res_v    = 1'b1;
            res_kind = KindPayload;
            res_id   = id_w;
            res_offs = offs_w;
            res_data = byte_q;
            res_len  = len_w;
            res_last = 1'b1;
            left_d   = '0;
            phase_d  = PhaseId;
          end else if (end_q) begin
            res_v    = 1'b1;
            res_kind = KindMalformed;
            res_id   = id_w;
            res_len  = len_w;
            stop     = 1'b1;
          end else begin
            res_v    = 1'b1;
            res_kind = KindPayload;
            res_id   = id_w;
            res_offs = offs_w;
            res_data = byte_q;
            res_len  = len_w;
            left_d   = left_w - 8'd1;
            offs_d   = offs_w + 8'd1;
          end
        end
        default: begin
          phase_d = PhaseId;
        end
      endcase
    end

    if (stop || end_q) begin
      mode_d  = ModeIgnore;
      phase_d = PhaseId;
      left_d  = '0;
      offs_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIgnore;
      phase_q <= PhaseId;
      id_q    <= '0;
      len_q   <= '0;
      left_q  <= '0;
      offs_q  <= '0;
    end else if (advance) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      left_q  <= left_d;
      offs_q  <= offs_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance && res_v) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_v) begin
      kind_o            <= res_kind;
      element_id_o      <= res_id;
      two_byte_format_o <= (mode_w == ModeTwo);
      byte_offset_o     <= res_offs;
      payload_byte_o    <= res_data;
      element_length_o  <= res_len;
      element_last_o    <= res_last;
    end
  end

  // assertions
  a_ignore_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeIgnore) |-> (phase_q == PhaseId))
    else $error("parser phase left idle while ignoring bytes");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhaseData) |-> (left_q != 8'd0))
    else $error("inside element data with no bytes left");

  a_last_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindPayload && element_last_o)
      |-> (byte_offset_o == element_length_o - 8'd1))
    else $error("last payload beat offset does not match element length");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o != 2'd3))
    else $error("illegal result kind");

endmodule

[tb/tb_rtp_header_extension_parser.sv]
// Self-checking bench for rtp_header_extension_parser: random and directed
// extension blocks in, parsed results checked against an in-bench predictor.
// Depends on rtphx_pkg and the parser RTL.
module tb_rtp_header_extension_parser;
  import rtphx_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 105;

  typedef struct packed {
    logic [7:0]  data;
    logic        blk_start;
    logic        blk_end;
    logic [15:0] prof;
  } ext_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] id;
    logic       two;
    logic [7:0] offs;
    logic [7:0] data;
    logic [7:0] len;
    logic       last;
  } parsed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  ext_byte = 8'h00;
  logic        block_start = 1'b0;
  logic        block_end = 1'b0;
  logic [15:0] profile_word = 16'h0000;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  element_id_o;
  logic        two_byte_format_o;
  logic [7:0]  byte_offset_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  element_length_o;
  logic        element_last_o;

  ext_beat_t byte_q[$];
  parsed_t   parsed_q[$];
  ext_beat_t next_beat;
  parsed_t   got;
  int        send_idle = 29;
  int        recv_idle = 80;
  int        mismatches = 0;
  int        cycles = 0;
  int        random_items;

  // predictor state
  mode_e      p_mode = ModeIgnore;
  phase_e     p_phase = PhaseId;
  logic [7:0] p_id = '0;
  logic [7:0] p_len = '0;
  logic [7:0] p_left = '0;
  logic [7:0] p_off = '0;

  rtp_header_extension_parser u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .ext_byte_i       (ext_byte),
    .block_start_i    (block_start),
    .block_end_i      (block_end),
    .profile_word_i   (profile_word),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .kind_o           (kind_o),
    .element_id_o     (element_id_o),
    .two_byte_format_o(two_byte_format_o),
    .byte_offset_o    (byte_offset_o),
    .payload_byte_o   (payload_byte_o),
    .element_length_o (element_length_o),
    .element_last_o   (element_last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic parsed_t make_parsed(logic [1:0] kind, logic [7:0] id, logic [7:0] offs,
                                          logic [7:0] data, logic [7:0] len, logic last);
    parsed_t r;
    r.kind = kind;
    r.id   = id;
    r.two  = (p_mode == ModeTwo);
    r.offs = offs;
    r.data = data;
    r.len  = len;
    r.last = last;
    return r;
  endfunction

  // Advance the parser state by one accepted beat; queue the result it causes.
  task automatic parse_beat(input ext_beat_t bt);
    logic [7:0] id;
    logic       stop;
    stop = 1'b0;
    if (bt.blk_start) begin
      if (bt.prof == ProfileOneByte) p_mode = ModeOne;
      else if ((bt.prof & ProfileTwoMask) == ProfileTwoByte) p_mode = ModeTwo;
      else p_mode = ModeIgnore;
      p_phase = PhaseId;
      p_id = '0;
      p_len = '0;
      p_left = '0;
      p_off = '0;
    end
    if (p_mode == ModeIgnore) begin
      p_phase = PhaseId;
    end else begin
      case (p_phase)
        PhaseId: begin
          id = (p_mode == ModeOne) ? {4'h0, bt.data[7:4]} : bt.data;
          if (id != 8'h00) begin
            p_id = id;
            if (id >= IdReserved) begin
              parsed_q.push_back(make_parsed(KindMalformed, id, 8'd0, 8'd0, 8'd0, 1'b0));
              stop = 1'b1;
            end else if (p_mode == ModeOne) begin
              p_len = {4'h0, bt.data[3:0]} + 8'd1;
              if (bt.blk_end) begin
                parsed_q.push_back(make_parsed(KindMalformed, id, 8'd0, 8'd0, p_len, 1'b0));
                stop = 1'b1;
              end else begin
                p_left = p_len;
                p_off = '0;
                p_phase = PhaseData;
              end
            end else begin
              p_len = '0;
              if (bt.blk_end) begin
                parsed_q.push_back(make_parsed(KindMalformed, id, 8'd0, 8'd0, 8'd0, 1'b0));
                stop = 1'b1;
              end else begin
                p_phase = PhaseLen;
              end
            end
          end
        end
        PhaseLen: begin
          p_len = bt.data;
          if (bt.data == 8'h00) begin
            parsed_q.push_back(make_parsed(KindEmpty, p_id, 8'd0, 8'd0, 8'd0, 1'b1));
            p_phase = PhaseId;
          end else if (bt.blk_end) begin
            parsed_q.push_back(make_parsed(KindMalformed, p_id, 8'd0, 8'd0, bt.data, 1'b0));
            stop = 1'b1;
          end else begin
            p_left = bt.data;
            p_off = '0;
            p_phase = PhaseData;
          end
        end
        default: begin
          if (p_left <= 8'd1) begin
            parsed_q.push_back(make_parsed(KindPayload, p_id, p_off, bt.data, p_len, 1'b1));
            p_left = '0;
            p_phase = PhaseId;
          end else if (bt.blk_end) begin
            parsed_q.push_back(make_parsed(KindMalformed, p_id, 8'd0, 8'd0, p_len, 1'b0));
            stop = 1'b1;
          end else begin
            parsed_q.push_back(make_parsed(KindPayload, p_id, p_off, bt.data, p_len, 1'b0));
            p_left = p_left - 8'd1;
            p_off = p_off + 8'd1;
          end
        end
      endcase
      if (stop || bt.blk_end) begin
        p_mode = ModeIgnore;
        p_phase = PhaseId;
        p_left = '0;
        p_off = '0;
      end
    end
  endtask

  function automatic void check_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  // Driver: present the next beat once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_ready_o) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          next_beat = byte_q.pop_front();
          in_valid     <= 1'b1;
          ext_byte     <= next_beat.data;
          block_start  <= next_beat.blk_start;
          block_end    <= next_beat.blk_end;
          profile_word <= next_beat.prof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on input beats, then check output beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        parse_beat({ext_byte, block_start, block_end, profile_word});
      end
      if (out_valid_o && out_ready) begin
        if (parsed_q.size() == 0) begin
          $error("unexpected result: kind %0d id %0d", kind_o, element_id_o);
          mismatches++;
        end else begin
          got = parsed_q.pop_front();
          check_field("kind", int'(got.kind), int'(kind_o));
          check_field("element_id", int'(got.id), int'(element_id_o));
          check_field("two_byte_format", int'(got.two), int'(two_byte_format_o));
          check_field("byte_offset", int'(got.offs), int'(byte_offset_o));
          check_field("payload_byte", int'(got.data), int'(payload_byte_o));
          check_field("element_length", int'(got.len), int'(element_length_o));
          check_field("element_last", int'(got.last), int'(element_last_o));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_rtp_header_extension_parser: FAIL");
      $finish;
    end
  end

  task automatic add_beat(input logic [7:0] d, input logic s, input logic e,
                          input logic [15:0] p);
    byte_q.push_back({d, s, e, p});
  endtask

  // One random extension block, well formed unless broken is set.
  task automatic gen_block(input bit broken);
    logic [7:0]  blk[$];
    logic [15:0] prof;
    logic [3:0]  nib;
    bit          two;
    bit          known;
    bit          no_end;
    int          r;
    int          len;
    int          n_el;
    r = $urandom_range(99);
    no_end = 1'b0;
    if (r < 45) prof = ProfileOneByte;
    else if (r < 90) prof = ProfileTwoByte | 16'($urandom_range(15));
    else prof = 16'($urandom_range(65535));
    two = ((prof & ProfileTwoMask) == ProfileTwoByte);
    known = two || (prof == ProfileOneByte);
    n_el = $urandom_range(1, 4);
    for (int k = 0; k < n_el; k++) begin
      if ($urandom_range(3) == 0) blk.push_back(two ? 8'h00 : {4'h0, 4'($urandom_range(15))});
      if (two) begin
        blk.push_back(8'($urandom_range(1, 14)));
        r = $urandom_range(99);
        if (r < 20) len = 0;
        else if (r < 23) len = $urandom_range(255);
        else len = $urandom_range(1, 6);
        blk.push_back(8'(len));
      end else begin
        nib = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        blk.push_back({4'($urandom_range(1, 14)), nib});
        len = nib + 1;
      end
      for (int j = 0; j < len; j++) blk.push_back(8'($urandom));
    end
    if (broken) begin
      case ($urandom_range(2))
        0: begin
          len = $urandom_range(1, blk.size());
          while (blk.size() > len) void'(blk.pop_back());
        end
        1: begin
          blk.push_back(two ? 8'($urandom_range(15, 255)) : {4'hF, 4'($urandom_range(15))});
          repeat ($urandom_range(3)) blk.push_back(8'($urandom));
        end
        default: no_end = 1'b1;
      endcase
    end
    foreach (blk[i]) begin
      add_beat(blk[i], i == 0, (i == blk.size() - 1) && !no_end,
               (i == 0) ? prof : 16'($urandom_range(65535)));
    end
    if (known) random_items += blk.size();
    // stray bytes between blocks
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        add_beat(8'($urandom), 1'b0, 1'($urandom_range(1)), 16'($urandom_range(65535)));
      end
    end
  endtask

  task automatic gen_random_phase();
    random_items = 0;
    while (random_items < PhaseItems) gen_block($urandom_range(3) == 0);
  endtask

  initial begin
    // byte before any block start
    add_beat(8'hFF, 1'b0, 1'b0, ProfileOneByte);
    // one-byte form: padding, two elements
    add_beat(8'h00, 1'b1, 1'b0, ProfileOneByte);
    add_beat(8'h10, 1'b0, 1'b0, 16'h0000);
    add_beat(8'hA5, 1'b0, 1'b0, 16'h0000);
    add_beat(8'h0F, 1'b0, 1'b0, 16'h0000);
    add_beat(8'h21, 1'b0, 1'b0, 16'h0000);
    add_beat(8'h00, 1'b0, 1'b0, 16'h0000);
    add_beat(8'hFF, 1'b0, 1'b1, 16'h0000);
    // two-byte form: padding, empty element, reserved id, then ignored byte
    add_beat(8'h00, 1'b1, 1'b0, 16'h100F);
    add_beat(8'h05, 1'b0, 1'b0, 16'hFFFF);
    add_beat(8'h00, 1'b0, 1'b0, 16'hFFFF);
    add_beat(8'hFE, 1'b0, 1'b0, 16'hFFFF);
    add_beat(8'h33, 1'b0, 1'b1, 16'hFFFF);
    // two-byte element cut short by block end
    add_beat(8'h0E, 1'b1, 1'b0, ProfileTwoByte);
    add_beat(8'h03, 1'b0, 1'b0, 16'h0000);
    add_beat(8'h11, 1'b0, 1'b0, 16'h0000);
    add_beat(8'h22, 1'b0, 1'b1, 16'h0000);
    // one-byte reserved id, then ignored rest of block
    add_beat(8'hF3, 1'b1, 1'b0, ProfileOneByte);
    add_beat(8'h10, 1'b0, 1'b1, 16'h0000);
    // header that is also the block end
    add_beat(8'h1F, 1'b1, 1'b1, ProfileOneByte);
    // early block start into an unknown profile
    add_beat(8'h35, 1'b1, 1'b0, ProfileOneByte);
    add_beat(8'h01, 1'b0, 1'b0, 16'h0000);
    add_beat(8'h40, 1'b1, 1'b0, 16'h1234);
    add_beat(8'h50, 1'b0, 1'b1, 16'h0000);
    // empty element on the last byte; length byte at block end
    add_beat(8'h07, 1'b1, 1'b0, 16'h1001);
    add_beat(8'h00, 1'b0, 1'b1, 16'h0000);
    add_beat(8'h09, 1'b1, 1'b0, 16'h100A);
    add_beat(8'hFF, 1'b0, 1'b1, 16'h0000);
    gen_random_phase();

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() > 0) @(negedge clk_i);
    send_idle = 80;
    recv_idle = 29;
    gen_random_phase();
    while (byte_q.size() > 0) @(negedge clk_i);
    send_idle = 0;
    recv_idle = 0;
    gen_random_phase();

    while (byte_q.size() > 0 || in_valid) @(negedge clk_i);
    while (parsed_q.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb_rtp_header_extension_parser: PASS");
    end else begin
      $display("tb_rtp_header_extension_parser: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rtphx_pkg.sv
hdl/rtp_header_extension_parser.sv
tb/tb_rtp_header_extension_parser.sv
